### src/scgs_pkg.sv
// Shared types, constants and operation codes for the grouped substitution cipher.
// No dependencies; every other file imports this package.
package scgs_pkg;

    // Alphabet and output grouping
    localparam int ALPHABET_SIZE   = 26;
    localparam int GROUP_LENGTH    = 5;
    localparam int GROUPS_PER_LINE = 10;

    localparam int LETTER_W = $clog2(ALPHABET_SIZE);
    localparam int CNT_W    = $clog2(ALPHABET_SIZE + 1);
    localparam int GRP_W    = (GROUP_LENGTH > 1) ? $clog2(GROUP_LENGTH) : 1;
    localparam int LINE_W   = (GROUPS_PER_LINE > 1) ? $clog2(GROUPS_PER_LINE) : 1;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic [1:0] OP_KEY      = 2'd0;
    localparam logic [1:0] OP_KEY_DONE = 2'd1;
    localparam logic [1:0] OP_TEXT     = 2'd2;
    localparam logic [1:0] OP_END      = 2'd3;

    // Characters
    localparam logic [7:0] CHAR_A       = 8'd65;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [7:0] CHAR_Z       = 8'd90;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_LF      = 8'd10;
    localparam logic [7:0] CHAR_NONE    = 8'd0;

    // Beat slots of one job, emitted from low to high
    localparam int BEAT_W     = 4;
    localparam int BEAT_CHAR  = 0;
    localparam int BEAT_SPACE = 1;
    localparam int BEAT_CR    = 2;
    localparam int BEAT_LF    = 3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       key_error;
        logic       last;
    } chr_t;

    typedef struct packed {
        logic [BEAT_W-1:0] beats;
        logic              has_letter;
        logic [7:0]        letter;
        logic              key_error;
    } job_t;

endpackage

### src/scgs_front.sv
// Front end: accepts command beats, runs key loading, table lookup and grouping.
// Pushes one job per result-producing command into the job queue. Uses scgs_pkg.
module scgs_front import scgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    input  logic queue_full,
    input  logic cfg_valid,
    input  logic cfg_data,
    output logic push,
    output job_t job
);

    logic [LETTER_W-1:0] fwd_reg [ALPHABET_SIZE];
    logic [LETTER_W-1:0] inv_reg [ALPHABET_SIZE];

    logic [ALPHABET_SIZE-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]         key_cnt_reg, key_cnt_next;
    logic                     dup_reg, dup_next;
    logic                     key_bad_reg, key_bad_next;
    logic [GRP_W-1:0]         lig_reg, lig_next;
    logic [LINE_W-1:0]        gil_reg, gil_next;
    logic                     decrypt_reg;

    logic                accept;
    logic [7:0]          folded;
    logic                is_letter;
    logic [LETTER_W-1:0] li;
    logic [LETTER_W-1:0] lookup_idx;
    logic [LETTER_W-1:0] mapped;
    logic [LETTER_W-1:0] mapped_fix;
    logic                grp_full;
    logic                line_full;
    logic                tbl_we;

    assign accept = cmd_valid && !queue_full;

    // Fold case and classify the byte
    assign folded = (cmd.byte_value >= CHAR_LOWER_A && cmd.byte_value <= CHAR_LOWER_Z)
                    ? cmd.byte_value - CASE_OFFSET : cmd.byte_value;
    assign is_letter  = (folded >= CHAR_A) && (folded <= CHAR_Z);
    assign li         = LETTER_W'(folded - CHAR_A);
    assign lookup_idx = is_letter ? li : '0;

    // Look up the substitute letter
    assign mapped     = decrypt_reg ? inv_reg[lookup_idx] : fwd_reg[lookup_idx];
    assign mapped_fix = (mapped >= LETTER_W'(ALPHABET_SIZE)) ? '0 : mapped;

    assign grp_full  = (lig_reg == GRP_W'(GROUP_LENGTH - 1));
    assign line_full = (gil_reg == LINE_W'(GROUPS_PER_LINE - 1));

    // Decide next state and the job to queue
    always_comb
    begin
        seen_next    = seen_reg;
        key_cnt_next = key_cnt_reg;
        dup_next     = dup_reg;
        key_bad_next = key_bad_reg;
        lig_next     = lig_reg;
        gil_next     = gil_reg;
        tbl_we       = 1'b0;
        push         = 1'b0;
        job          = '0;
        if (accept)
        begin
            unique case (cmd.op)
                OP_KEY:
                begin
                    key_bad_next = 1'b1;
                    if (is_letter)
                    begin
                        if (key_cnt_reg >= CNT_W'(ALPHABET_SIZE))
                        begin
                            dup_next = 1'b1;
                        end
                        else
                        begin
                            if (seen_reg[li])
                            begin
                                dup_next = 1'b1;
                            end
                            else
                            begin
                                seen_next[li] = 1'b1;
                                tbl_we        = 1'b1;
                            end
                            key_cnt_next = key_cnt_reg + 1'b1;
                        end
                    end
                end
                OP_KEY_DONE:
                begin
                    key_bad_next  = !((key_cnt_reg == CNT_W'(ALPHABET_SIZE)) && !dup_reg);
                    seen_next     = '0;
                    key_cnt_next  = '0;
                    dup_next      = 1'b0;
                    push          = 1'b1;
                    job.beats     = BEAT_W'(1) << BEAT_CHAR;
                    job.key_error = key_bad_next;
                end
                OP_TEXT:
                begin
                    if (key_bad_reg)
                    begin
                        push          = 1'b1;
                        job.beats     = BEAT_W'(1) << BEAT_CHAR;
                        job.key_error = 1'b1;
                    end
                    else if (is_letter)
                    begin
                        push                 = 1'b1;
                        job.has_letter       = 1'b1;
                        job.letter           = CHAR_A + 8'(mapped_fix);
                        job.beats[BEAT_CHAR] = 1'b1;
                        if (grp_full)
                        begin
                            lig_next              = '0;
                            job.beats[BEAT_SPACE] = 1'b1;
                            if (line_full)
                            begin
                                gil_next           = '0;
                                job.beats[BEAT_CR] = 1'b1;
                                job.beats[BEAT_LF] = 1'b1;
                            end
                            else
                            begin
                                gil_next = gil_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            lig_next = lig_reg + 1'b1;
                        end
                    end
                end
                OP_END:
                begin
                    push               = 1'b1;
                    job.beats[BEAT_CR] = 1'b1;
                    job.beats[BEAT_LF] = 1'b1;
                    job.key_error      = key_bad_reg;
                    lig_next           = '0;
                    gil_next           = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            key_cnt_reg <= '0;
            dup_reg     <= 1'b0;
            key_bad_reg <= 1'b1;
            lig_reg     <= '0;
            gil_reg     <= '0;
            decrypt_reg <= 1'b0;
        end
        else
        begin
            seen_reg    <= seen_next;
            key_cnt_reg <= key_cnt_next;
            dup_reg     <= dup_next;
            key_bad_reg <= key_bad_next;
            lig_reg     <= lig_next;
            gil_reg     <= gil_next;
            if (cfg_valid)
            begin
                decrypt_reg <= cfg_data;
            end
        end
    end

    // Write the forward and inverse tables on a new key letter
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            fwd_reg[key_cnt_reg[LETTER_W-1:0]] <= li;
            inv_reg[li]                        <= key_cnt_reg[LETTER_W-1:0];
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_cnt_reg <= CNT_W'(ALPHABET_SIZE))
        else $error("key letter count exceeds alphabet size");

    a_key_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == OP_KEY_DONE) |=> (key_cnt_reg == '0 && seen_reg == '0 && !dup_reg))
        else $error("key state not cleared after key done");

endmodule

### src/scgs_queue.sv
// Small job queue decoupling the front end from the output sequencer.
// Register-based FIFO of job_t entries from scgs_pkg.
module scgs_queue import scgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### src/scgs_back.sv
// Back end: expands queued jobs into character beats through an output register.
// One beat per unstalled cycle; letter, space, CR, LF in order. Uses scgs_pkg.
module scgs_back import scgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic queue_empty,
    input  job_t head,
    output logic pop,
    output logic chr_valid,
    input  logic chr_stall,
    output chr_t chr
);

    logic [BEAT_W-1:0] mask_reg;
    logic              has_letter_reg;
    logic [7:0]        letter_reg;
    logic              kerr_reg;
    logic              chr_valid_reg;
    chr_t              chr_reg;

    logic              from_queue;
    logic              src_valid;
    logic [BEAT_W-1:0] src_mask;
    logic              src_has_letter;
    logic [7:0]        src_letter;
    logic              src_kerr;
    logic [BEAT_W-1:0] pick;
    logic [BEAT_W-1:0] rest;
    logic              load;
    chr_t              beat;

    // Pick the source: leftover beats of the current job, else the queue head
    assign from_queue     = (mask_reg == '0);
    assign src_valid      = !from_queue || !queue_empty;
    assign src_mask       = from_queue ? head.beats : mask_reg;
    assign src_has_letter = from_queue ? head.has_letter : has_letter_reg;
    assign src_letter     = from_queue ? head.letter : letter_reg;
    assign src_kerr       = from_queue ? head.key_error : kerr_reg;

    assign pick = src_mask & (~src_mask + 1'b1);
    assign rest = src_mask & ~pick;
    assign load = src_valid && (!chr_valid_reg || !chr_stall);
    assign pop  = load && from_queue;

    // Build the next beat
    always_comb
    begin
        beat.key_error = src_kerr;
        beat.last      = (rest == '0);
        beat.has_char  = 1'b1;
        priority if (pick[BEAT_CHAR])
        begin
            beat.out_char = src_has_letter ? src_letter : CHAR_NONE;
            beat.has_char = src_has_letter;
        end
        else if (pick[BEAT_SPACE])
        begin
            beat.out_char = CHAR_SPACE;
        end
        else if (pick[BEAT_CR])
        begin
            beat.out_char = CHAR_CR;
        end
        else
        begin
            beat.out_char = CHAR_LF;
        end
    end

    // Control: remaining beats and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            chr_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                mask_reg      <= rest;
                chr_valid_reg <= 1'b1;
            end
            else if (!chr_stall)
            begin
                chr_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold job fields and the output beat
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            has_letter_reg <= head.has_letter;
            letter_reg     <= head.letter;
            kerr_reg       <= head.key_error;
        end
        if (load)
        begin
            chr_reg <= beat;
        end
    end

    assign chr_valid = chr_valid_reg;
    assign chr       = chr_reg;

    a_pop_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (mask_reg == '0))
        else $error("queue popped while beats of a job remain");

    a_pending_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg != '0) |-> chr_valid_reg)
        else $error("pending beats without a beat in the output register");

endmodule

### src/substitution_cipher_grouped_stream.sv
// Top level of the grouped substitution cipher stream block.
// Instantiates scgs_front, scgs_queue and scgs_back; uses scgs_pkg.

// Byte-stream substitution cipher with five-letter groups and ten groups per line.
// Command beats (key byte, key done, text byte, end of text) are taken one per
// cycle while the four-entry job queue has room; the front end decides every
// command in the cycle it is accepted. Results leave one beat per cycle from a
// registered output while chr_stall is low, so a letter gives one to four beats
// (four when it closes a line), and the sustained rate is set by that output
// port. The first beat of a command passes through the job queue and then the
// output register. Commands that give no result (key bytes, non-letter text
// under a valid key) use no queue slot. The mode register is always ready;
// write it only while the block is idle.
module substitution_cipher_grouped_stream import scgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic chr_valid,
    input  logic chr_stall,
    output chr_t chr,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    logic push;
    job_t push_job;
    logic pop;
    job_t head;
    logic queue_empty;
    logic queue_full;

    assign cmd_stall = queue_full;
    assign cfg_ready = 1'b1;

    scgs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .queue_full (queue_full),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .push       (push),
        .job        (push_job)
    );

    scgs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    scgs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .chr_valid   (chr_valid),
        .chr_stall   (chr_stall),
        .chr         (chr)
    );

endmodule

### bench/testbench.sv
// Self-checking bench for substitution_cipher_grouped_stream: directed rows, then random
// key/text sequences checked beat by beat against a cipher predictor kept in this file.
// Depends on scgs_pkg and the block's top level only.
module testbench;
    import scgs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 200;
    localparam int QUIET_TAIL    = 60;
    localparam int REPORT_MAX    = 40;

    // One row of the directed table: a run of command beats or a mode write
    typedef struct packed {
        logic            is_cfg;
        logic [1:0]      op;
        logic [7:0]      start_byte;
        logic [5:0]      reps;
        logic [7:0]      stride;
        logic [2:0]      n_typed;
        chr_t [3:0]      typed;
    } stim_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic chr_valid;
    logic chr_stall = 1'b0;
    chr_t chr;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data  = 1'b0;

    // Expectation typed into the table, carried alongside the command beat
    int         typed_n     = 0;
    chr_t [3:0] typed_beats = '0;

    int  cycle_count = 0;
    int  fail_count  = 0;
    int  sent_count  = 0;
    bit  quiet       = 1'b0;
    bit  tx_noisy    = 1'b1;
    bit  rx_noisy    = 1'b1;
    int  rx_window   = 0;
    int  stall_left  = 0;

    chr_t      expected_chars[$];
    stim_row_t stim_rows[$];

    // Cipher state mirrored from the block
    logic [4:0]  fwd_map[ALPHABET_SIZE];
    logic [4:0]  inv_map[ALPHABET_SIZE];
    logic [25:0] seen_mask;
    int          key_count;
    logic        dup_flag;
    logic        key_invalid;
    int          group_pos;
    int          line_pos;
    logic        decrypt_sel;

    // Beats predicted for the command being accepted
    logic [7:0] pred_char[4];
    logic       pred_has[4];
    logic       pred_err[4];
    int         pred_n;

    substitution_cipher_grouped_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr       (chr),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Fold case; give the letter index or -1 for anything else
    function automatic int letter_code(input logic [7:0] b);
        logic [7:0] u;
        u = b;
        if (u >= CHAR_LOWER_A && u <= CHAR_LOWER_Z)
            u = u - CASE_OFFSET;
        if (u >= CHAR_A && u <= CHAR_Z)
            return int'(u - CHAR_A);
        return -1;
    endfunction

    function automatic logic [7:0] letter_byte(input int idx);
        logic [7:0] b;
        b = CHAR_A + 8'(idx);
        if ($urandom_range(0, 1) != 0)
            b = b | CASE_OFFSET;
        return b;
    endfunction

    function automatic logic [7:0] random_nonletter();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (letter_code(b) >= 0)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic chr_t beat(input logic [7:0] ch, input logic has, input logic err,
                                  input logic fin);
        chr_t t;
        t.out_char  = ch;
        t.has_char  = has;
        t.key_error = err;
        t.last      = fin;
        return t;
    endfunction

    function automatic stim_row_t row_run(input logic [1:0] op, input logic [7:0] start,
                                          input int reps, input logic [7:0] stride);
        stim_row_t r;
        r            = '0;
        r.op         = op;
        r.start_byte = start;
        r.reps       = 6'(reps);
        r.stride     = stride;
        return r;
    endfunction

    function automatic stim_row_t row_typed(input logic [1:0] op, input logic [7:0] b,
                                            input int n, input chr_t t0, input chr_t t1);
        stim_row_t r;
        r            = '0;
        r.op         = op;
        r.start_byte = b;
        r.reps       = 6'd1;
        r.n_typed    = 3'(n);
        r.typed[0]   = t0;
        r.typed[1]   = t1;
        return r;
    endfunction

    function automatic stim_row_t row_cfg(input logic m);
        stim_row_t r;
        r            = '0;
        r.is_cfg     = 1'b1;
        r.start_byte = {7'd0, m};
        r.reps       = 6'd1;
        return r;
    endfunction

    task automatic add_beat(input logic [7:0] ch, input logic has);
        pred_char[pred_n] = ch;
        pred_has[pred_n]  = has;
        pred_err[pred_n]  = key_invalid;
        pred_n++;
    endtask

    // Advance the mirrored cipher by one command and collect its beats
    task automatic predict_cmd(input cmd_t c);
        int         li;
        logic [4:0] m;
        pred_n = 0;
        li     = letter_code(c.byte_value);
        case (c.op)
            OP_KEY:
            begin
                key_invalid = 1'b1;
                if (li >= 0)
                begin
                    if (key_count >= ALPHABET_SIZE)
                        dup_flag = 1'b1;
                    else
                    begin
                        if (seen_mask[li])
                            dup_flag = 1'b1;
                        else
                        begin
                            seen_mask[li]      = 1'b1;
                            fwd_map[key_count] = 5'(li);
                            inv_map[li]        = 5'(key_count);
                        end
                        key_count++;
                    end
                end
            end
            OP_KEY_DONE:
            begin
                key_invalid = !(key_count == ALPHABET_SIZE && !dup_flag);
                seen_mask   = '0;
                key_count   = 0;
                dup_flag    = 1'b0;
                add_beat(CHAR_NONE, 1'b0);
            end
            OP_TEXT:
            begin
                if (key_invalid)
                    add_beat(CHAR_NONE, 1'b0);
                else if (li >= 0)
                begin
                    m = decrypt_sel ? inv_map[li] : fwd_map[li];
                    add_beat(CHAR_A + 8'(m), 1'b1);
                    group_pos++;
                    if (group_pos >= GROUP_LENGTH)
                    begin
                        group_pos = 0;
                        add_beat(CHAR_SPACE, 1'b1);
                        line_pos++;
                        if (line_pos >= GROUPS_PER_LINE)
                        begin
                            line_pos = 0;
                            add_beat(CHAR_CR, 1'b1);
                            add_beat(CHAR_LF, 1'b1);
                        end
                    end
                end
            end
            default:
            begin
                add_beat(CHAR_CR, 1'b1);
                add_beat(CHAR_LF, 1'b1);
                group_pos = 0;
                line_pos  = 0;
            end
        endcase
    endtask

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Offer one command beat, with an occasional gap first, and hold it until taken
    task automatic send_checked(input logic [1:0] op, input logic [7:0] b, input int n_typed,
                                input chr_t [3:0] typed);
        cmd_t c;
        c.op         = op;
        c.byte_value = b;
        if (!quiet && tx_noisy && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        cmd         <= c;
        typed_n     <= n_typed;
        typed_beats <= typed;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_plain(input logic [1:0] op, input logic [7:0] b);
        send_checked(op, b, 0, '0);
    endtask

    // Drop valid and wait for every expected beat, then let the pipeline settle
    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Predict on accepted commands, check accepted result beats
    always @(posedge clk)
    begin : watch
        chr_t want;
        int   i;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                decrypt_sel = cfg_data;
            if (cmd_valid && !cmd_stall)
            begin
                predict_cmd(cmd);
                if (typed_n != 0)
                begin
                    for (i = 0; i < typed_n; i++)
                        expected_chars.push_back(typed_beats[i]);
                end
                else
                begin
                    for (i = 0; i < pred_n; i++)
                    begin
                        want.out_char  = pred_char[i];
                        want.has_char  = pred_has[i];
                        want.key_error = pred_err[i];
                        want.last      = (i == pred_n - 1);
                        expected_chars.push_back(want);
                    end
                end
            end
            if (chr_valid && !chr_stall)
            begin
                if (expected_chars.size() == 0)
                    report($sformatf("unexpected beat, out_char %0d", chr.out_char));
                else
                begin
                    want = expected_chars.pop_front();
                    if (chr.out_char !== want.out_char)
                        report($sformatf("out_char %0d, want %0d", chr.out_char,
                                         want.out_char));
                    if (chr.has_char !== want.has_char)
                        report($sformatf("has_char %b, want %b", chr.has_char,
                                         want.has_char));
                    if (chr.key_error !== want.key_error)
                        report($sformatf("key_error %b, want %b", chr.key_error,
                                         want.key_error));
                    if (chr.last !== want.last)
                        report($sformatf("last %b, want %b", chr.last, want.last));
                end
            end
        end
    end

    // Stall the result side in bursts; some windows stay clear
    always @(posedge clk)
    begin
        if (rx_window == 0)
        begin
            rx_window <= $urandom_range(20, 120);
            rx_noisy  <= ($urandom_range(0, 2) != 0);
        end
        else
            rx_window <= rx_window - 1;
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            chr_stall  <= 1'b1;
        end
        else if (!quiet && rx_noisy && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 12);
            chr_stall  <= 1'b1;
        end
        else
            chr_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        int        perm[ALPHABET_SIZE];
        int        i;
        int        j;
        int        t;
        int        pick;
        int        n_letters;
        int        len;
        int        r;
        int        random_goal;

        // Mirror of the reset state
        foreach (fwd_map[k])
        begin
            fwd_map[k] = '0;
            inv_map[k] = '0;
        end
        seen_mask   = '0;
        key_count   = 0;
        dup_flag    = 1'b0;
        key_invalid = 1'b1;
        group_pos   = 0;
        line_pos    = 0;
        decrypt_sel = 1'b0;

        // Directed rows: no key yet, short, duplicate and overlong keys, then a valid key
        stim_rows.push_back(row_cfg(1'b0));
        stim_rows.push_back(row_typed(OP_TEXT, CHAR_A, 1,
                                      beat(CHAR_NONE, 1'b0, 1'b1, 1'b1), '0));
        stim_rows.push_back(row_typed(OP_END, CHAR_NONE, 2,
                                      beat(CHAR_CR, 1'b1, 1'b1, 1'b0),
                                      beat(CHAR_LF, 1'b1, 1'b1, 1'b1)));
        stim_rows.push_back(row_typed(OP_KEY_DONE, CHAR_NONE, 1,
                                      beat(CHAR_NONE, 1'b0, 1'b1, 1'b1), '0));
        stim_rows.push_back(row_run(OP_KEY, CHAR_A, 5, 8'd1));
        stim_rows.push_back(row_typed(OP_KEY_DONE, CHAR_NONE, 1,
                                      beat(CHAR_NONE, 1'b0, 1'b1, 1'b1), '0));
        stim_rows.push_back(row_run(OP_KEY, CHAR_A, 25, 8'd1));
        stim_rows.push_back(row_run(OP_KEY, CHAR_A, 1, 8'd0));
        stim_rows.push_back(row_typed(OP_KEY_DONE, CHAR_NONE, 1,
                                      beat(CHAR_NONE, 1'b0, 1'b1, 1'b1), '0));
        stim_rows.push_back(row_run(OP_KEY, CHAR_LOWER_A, 26, 8'd1));
        stim_rows.push_back(row_run(OP_KEY, 8'd33, 1, 8'd0));
        stim_rows.push_back(row_run(OP_KEY, CHAR_A + 8'd16, 1, 8'd0));
        stim_rows.push_back(row_typed(OP_KEY_DONE, CHAR_NONE, 1,
                                      beat(CHAR_NONE, 1'b0, 1'b1, 1'b1), '0));
        stim_rows.push_back(row_run(OP_KEY, CHAR_LOWER_Z, 26, 8'hFF));
        stim_rows.push_back(row_run(OP_KEY, 8'h00, 2, 8'hFF));
        stim_rows.push_back(row_typed(OP_KEY_DONE, 8'hFF, 1,
                                      beat(CHAR_NONE, 1'b0, 1'b0, 1'b1), '0));
        stim_rows.push_back(row_run(OP_TEXT, CHAR_LOWER_A, 26, 8'd1));
        stim_rows.push_back(row_run(OP_TEXT, 8'h00, 2, 8'hFF));
        stim_rows.push_back(row_run(OP_TEXT, 8'd64, 2, 8'd27));
        stim_rows.push_back(row_run(OP_TEXT, 8'd96, 2, 8'd27));
        stim_rows.push_back(row_run(OP_TEXT, CHAR_A, 26, 8'd1));
        stim_rows.push_back(row_typed(OP_END, 8'hFF, 2,
                                      beat(CHAR_CR, 1'b1, 1'b0, 1'b0),
                                      beat(CHAR_LF, 1'b1, 1'b0, 1'b1)));
        stim_rows.push_back(row_cfg(1'b1));
        stim_rows.push_back(row_run(OP_TEXT, CHAR_Z, 12, 8'hFF));
        stim_rows.push_back(row_typed(OP_END, CHAR_NONE, 2,
                                      beat(CHAR_CR, 1'b1, 1'b0, 1'b0),
                                      beat(CHAR_LF, 1'b1, 1'b0, 1'b1)));
        stim_rows.push_back(row_run(OP_KEY, CHAR_LOWER_A, 1, 8'd0));
        stim_rows.push_back(row_typed(OP_TEXT, CHAR_A + 8'd1, 1,
                                      beat(CHAR_NONE, 1'b0, 1'b1, 1'b1), '0));
        stim_rows.push_back(row_typed(OP_KEY_DONE, CHAR_NONE, 1,
                                      beat(CHAR_NONE, 1'b0, 1'b1, 1'b1), '0));
        stim_rows.push_back(row_cfg(1'b0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (stim_rows[q])
        begin
            row = stim_rows[q];
            if (row.is_cfg)
                write_mode(row.start_byte[0]);
            else
                for (i = 0; i < row.reps; i++)
                    send_checked(row.op, row.start_byte + row.stride * 8'(i),
                                 int'(row.n_typed), row.typed);
        end

        // Random part: mostly full keys followed by text, some broken keys and noise
        random_goal = sent_count + RANDOM_ITEMS;
        while (sent_count < random_goal)
        begin
            quiet    = (sent_count >= random_goal - QUIET_TAIL);
            tx_noisy = ($urandom_range(0, 2) != 0);
            pick     = $urandom_range(0, 9);
            if (pick == 9)
                write_mode(1'($urandom_range(0, 1)));
            else if (pick == 8)
            begin
                len = $urandom_range(5, 15);
                for (i = 0; i < len; i++)
                    send_plain(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                for (i = 0; i < ALPHABET_SIZE; i++)
                    perm[i] = i;
                for (i = ALPHABET_SIZE - 1; i > 0; i--)
                begin
                    j       = $urandom_range(0, i);
                    t       = perm[i];
                    perm[i] = perm[j];
                    perm[j] = t;
                end
                n_letters = ALPHABET_SIZE;
                if (pick == 6)
                    n_letters = $urandom_range(0, ALPHABET_SIZE - 1);
                else if (pick == 7)
                begin
                    if ($urandom_range(0, 1) != 0)
                        perm[$urandom_range(1, ALPHABET_SIZE - 1)] = perm[0];
                    else
                        n_letters = $urandom_range(ALPHABET_SIZE + 1, ALPHABET_SIZE + 4);
                end
                for (i = 0; i < n_letters; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_plain(OP_KEY, random_nonletter());
                    send_plain(OP_KEY, letter_byte(perm[i % ALPHABET_SIZE]));
                end
                send_plain(OP_KEY_DONE, 8'($urandom_range(0, 255)));
                if (pick <= 5 && $urandom_range(0, 2) == 0)
                    write_mode(1'($urandom_range(0, 1)));
                len = (pick <= 5) ? $urandom_range(1, 70) : $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 39);
                    if (r == 0)
                        send_plain(OP_END, 8'($urandom_range(0, 255)));
                    else if (r < 6)
                        send_plain(OP_TEXT, 8'($urandom_range(0, 255)));
                    else
                        send_plain(OP_TEXT, letter_byte($urandom_range(0, ALPHABET_SIZE - 1)));
                end
                if ($urandom_range(0, 1) != 0)
                    send_plain(OP_END, 8'($urandom_range(0, 255)));
            end
        end

        quiet = 1'b1;
        drain_results();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
